// ===== rtl/gcd_pkg.sv =====
// Shared constants and elaboration-time helpers for the great-circle distance pipeline.
`timescale 1ns / 1ps
package gcd_pkg;

  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] KINV_Q60 = 64'd700114967507363238;
  localparam int          TAB_LEN  = 48;
  localparam logic [29:0] PI_OUT   = 30'd843314857;

  // Round a Q60 constant to f fraction bits, ties up
  function automatic logic [63:0] from_q60(logic [63:0] v, int f);
    logic [63:0] r;
    r = (v + (64'd1 << (59 - f))) >> (60 - f);
    return r;
  endfunction

  // atan(2^-i) in Q60 by its alternating series
  function automatic logic [63:0] atan_q60(int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          k;
    sum = 64'd0;
    if (i == 0) begin
      sum = (PI_Q60 + 64'd2) >> 2;
    end else begin
      for (k = 0; i * (2 * k + 1) <= 60; k++) begin
        term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

endpackage

// ===== rtl/gcd_delay.sv =====
// Resettable shift line that carries side data alongside the pipeline.
`timescale 1ns / 1ps
module gcd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [0:DEPTH-1];

  // Shift one place per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) tap_r[i] <= '0;
    end else begin
      tap_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

// ===== rtl/gcd_rot_cell.sv =====
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
`timescale 1ns / 1ps
module gcd_rot_cell
  import gcd_pkg::*;
#(
  parameter int FRAC_BITS = 28,
  parameter int W         = 34,
  parameter int STEP      = 0,
  parameter bit VECT      = 1'b0
) (
  input  logic                clk,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic signed [W-1:0] z_in,
  output logic signed [W-1:0] x_out,
  output logic signed [W-1:0] y_out,
  output logic signed [W-1:0] z_out
);

  localparam logic [63:0]         T64 = from_q60(atan_q60(STEP), FRAC_BITS);
  localparam logic signed [W-1:0] T   = W'(T64);

  logic signed [W-1:0] dx, dy;
  logic                up;
  logic signed [W-1:0] x_nxt, y_nxt, z_nxt;

  // Pick the direction and rotate
  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
    up = VECT ? !y_in[W-1] : z_in[W-1];
    if (VECT ? up : !up) begin
      x_nxt = VECT ? x_in + dx : x_in - dx;
      y_nxt = VECT ? y_in - dy : y_in + dy;
      z_nxt = VECT ? z_in + T  : z_in - T;
    end else begin
      x_nxt = VECT ? x_in - dx : x_in + dx;
      y_nxt = VECT ? y_in + dy : y_in - dy;
      z_nxt = VECT ? z_in - T  : z_in + T;
    end
  end

  // Hand on to the next cell
  always_ff @(posedge clk) begin
    x_out <= x_nxt;
    y_out <= y_nxt;
    z_out <= z_nxt;
  end

endmodule

// ===== rtl/gcd_root_cell.sv =====
// One bit of a restoring square root, registered.
`timescale 1ns / 1ps
module gcd_root_cell #(
  parameter int VW  = 58,
  parameter int RW  = 31,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic [VW-1:0] v_in,
  input  logic [RW-1:0] rem_in,
  input  logic [RW-1:0] root_in,
  output logic [VW-1:0] v_out,
  output logic [RW-1:0] rem_out,
  output logic [RW-1:0] root_out
);

  logic [RW-1:0] rem_sh, trial, rem_nxt, root_nxt;

  // Bring down two bits and try the next root bit
  always_comb begin
    rem_sh = {rem_in[RW-3:0], v_in[2*BIT+1], v_in[2*BIT]};
    trial  = {root_in[RW-3:0], 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_in[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_in[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    v_out    <= v_in;
    rem_out  <= rem_nxt;
    root_out <= root_nxt;
  end

endmodule

// ===== rtl/gcd_mul.sv =====
// Two-stage signed fixed-point multiply, rounded to nearest, ties away from zero.
`timescale 1ns / 1ps
module gcd_mul #(
  parameter int FRAC_BITS = 28,
  parameter int W         = 34
) (
  input  logic                clk,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] p
);

  localparam int SH = FRAC_BITS - FRAC_BITS / 2;
  localparam int PW = 2 * W;

  logic [W-1:0]  ua, ub;
  logic [PW-1:0] ua_e, ubh_e, ubl_e;
  logic [PW-1:0] hi_nxt, lo_nxt;
  logic [PW-1:0] hi_r, lo_r;
  logic          neg_r;
  logic [PW-1:0] mag;

  // Split the second operand and form partial products
  always_comb begin
    ua     = a[W-1] ? W'(-a) : W'(a);
    ub     = b[W-1] ? W'(-b) : W'(b);
    ua_e   = {{W{1'b0}}, ua};
    ubh_e  = {{W{1'b0}}, ub} >> SH;
    ubl_e  = {{W{1'b0}}, ub} & ((PW'(1) << SH) - PW'(1));
    hi_nxt = ua_e * ubh_e;
    lo_nxt = ua_e * ubl_e + (PW'(1) << (FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    neg_r <= a[W-1] ^ b[W-1];
  end

  // Combine, drop fraction bits and restore the sign
  always_comb begin
    mag = (hi_r + (lo_r >> SH)) >> (FRAC_BITS - SH);
  end

  always_ff @(posedge clk) begin
    p <= neg_r ? -W'(mag) : W'(mag);
  end

endmodule

// ===== rtl/great_circle_distance_top.sv =====
// Top level of the pipelined haversine great-circle distance block.
//
// Usage: drive the four point coordinates (signed Q4.28 radians) with start
// high; busy is never raised, so a new point pair is taken every cycle.
// The separation (unsigned Q2.28 radians, 0 to pi) appears on out_separation
// with out_valid high for exactly one cycle. Each point pair passes in order
// through the rescale, reduce and fold stages, the rotation cell rows for the
// four sines and cosines (NS cells each, where NS is CORDIC_STEPS capped at
// 48), the two chained two-stage multipliers, the FRAC_BITS + 1 root cells,
// the vectoring cell row and the output register. Throughput is one beat per
// cycle.
// Reset clears the valid pipeline; beats in flight are dropped.
// The receiver cannot stall: each result is shown for one cycle only.
`timescale 1ns / 1ps
module great_circle_distance_top
  import gcd_pkg::*;
#(
  parameter int FRAC_BITS    = 28,
  parameter int CORDIC_STEPS = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_lon_first,
  input  logic signed [31:0] in_lat_first,
  input  logic signed [31:0] in_lon_second,
  input  logic signed [31:0] in_lat_second,
  output logic               out_valid,
  output logic [29:0]        out_separation
);

  localparam int W   = FRAC_BITS + 6;
  localparam int NS  = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int VW  = 2 * FRAC_BITS + 2;
  localparam int RW  = FRAC_BITS + 3;
  localparam int LAT = 2 * NS + FRAC_BITS + 11;

  localparam logic signed [W-1:0] PI_F  = W'(from_q60(PI_Q60, FRAC_BITS));
  localparam logic signed [W-1:0] HP_F  = W'(from_q60(PI_Q60 >> 1, FRAC_BITS));
  localparam logic signed [W-1:0] TPI_F = W'(2 * from_q60(PI_Q60, FRAC_BITS));
  localparam logic signed [W-1:0] K_F   = W'(from_q60(KINV_Q60, FRAC_BITS));
  localparam logic signed [W-1:0] ONE_F = W'(1) <<< FRAC_BITS;

  assign busy = 1'b0;

  // Valid strobe travels alongside the data
  gcd_delay #(.WIDTH(1), .DEPTH(LAT)) u_vld (
    .clk(clk), .rst_n(rst_n), .din(start), .dout(out_valid)
  );

  // Stage 0: half differences and latitudes in Q(F)
  logic signed [32:0] src [0:3];
  logic signed [63:0] src64 [0:3];
  logic signed [W-1:0] ang_r [0:3];

  assign src[0] = 33'(in_lon_second) - 33'(in_lon_first);
  assign src[1] = 33'(in_lat_second) - 33'(in_lat_first);
  assign src[2] = 33'(in_lat_first);
  assign src[3] = 33'(in_lat_second);

  generate
    for (genvar l = 0; l < 4; l++) begin : g_rescale
      localparam int SRCF = (l < 2) ? 29 : 28;
      if (FRAC_BITS >= SRCF) begin : g_up
        assign src64[l] = 64'(src[l]) <<< (FRAC_BITS - SRCF);
      end else begin : g_dn
        assign src64[l] = (64'(src[l]) + (64'sd1 <<< (SRCF - FRAC_BITS - 1)))
                          >>> (SRCF - FRAC_BITS);
      end
      always_ff @(posedge clk) ang_r[l] <= W'(src64[l]);
    end
  endgenerate

  // Stage 1: reduce into (-pi, pi]
  logic signed [W-1:0] red_r [0:3];
  logic signed [W-1:0] r1 [0:3];
  logic signed [W-1:0] r2 [0:3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (ang_r[l] < 0) r1[l] = ang_r[l] + TPI_F;
      else if (ang_r[l] >= TPI_F) r1[l] = ang_r[l] - TPI_F;
      else r1[l] = ang_r[l];
      r2[l] = (r1[l] < 0) ? r1[l] + TPI_F : r1[l];
      if (r2[l] > PI_F) r2[l] = r2[l] - TPI_F;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) red_r[l] <= r2[l];
  end

  // Stage 2: fold into [-pi/2, pi/2], note a negated cosine
  logic signed [W-1:0] fold_r [0:3];
  logic [3:0]          neg_r;
  logic [3:0]          neg_d;

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (red_r[l] > HP_F) begin
        fold_r[l] <= PI_F - red_r[l];
        neg_r[l]  <= 1'b1;
      end else if (red_r[l] < -HP_F) begin
        fold_r[l] <= -PI_F - red_r[l];
        neg_r[l]  <= 1'b1;
      end else begin
        fold_r[l] <= red_r[l];
        neg_r[l]  <= 1'b0;
      end
    end
  end

  gcd_delay #(.WIDTH(4), .DEPTH(NS)) u_neg (
    .clk(clk), .rst_n(rst_n), .din(neg_r), .dout(neg_d)
  );

  // Rotation cell rows, one lane per angle
  logic signed [W-1:0] rx [0:3][0:NS];
  logic signed [W-1:0] ry [0:3][0:NS];
  logic signed [W-1:0] rz [0:3][0:NS];

  generate
    for (genvar l = 0; l < 4; l++) begin : g_rlane
      assign rx[l][0] = K_F;
      assign ry[l][0] = '0;
      assign rz[l][0] = fold_r[l];
      for (genvar c = 0; c < NS; c++) begin : g_rcell
        gcd_rot_cell #(.FRAC_BITS(FRAC_BITS), .W(W), .STEP(c), .VECT(1'b0)) u_cell (
          .clk(clk),
          .x_in(rx[l][c]), .y_in(ry[l][c]), .z_in(rz[l][c]),
          .x_out(rx[l][c+1]), .y_out(ry[l][c+1]), .z_out(rz[l][c+1])
        );
      end
    end
  endgenerate

  // Sines and signed cosines
  logic signed [W-1:0] sin_r [0:3];
  logic signed [W-1:0] cos_r [0:3];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      sin_r[l] <= ry[l][NS];
      cos_r[l] <= neg_d[l] ? -rx[l][NS] : rx[l][NS];
    end
  end

  // Products of the haversine term
  logic signed [W-1:0] p_lat, p_cc, p_lon, p_lat_d, p_mix;

  gcd_mul #(.FRAC_BITS(FRAC_BITS), .W(W)) u_mul_lat (
    .clk(clk), .a(sin_r[1]), .b(sin_r[1]), .p(p_lat)
  );
  gcd_mul #(.FRAC_BITS(FRAC_BITS), .W(W)) u_mul_cc (
    .clk(clk), .a(cos_r[2]), .b(cos_r[3]), .p(p_cc)
  );
  gcd_mul #(.FRAC_BITS(FRAC_BITS), .W(W)) u_mul_lon (
    .clk(clk), .a(sin_r[0]), .b(sin_r[0]), .p(p_lon)
  );
  gcd_mul #(.FRAC_BITS(FRAC_BITS), .W(W)) u_mul_mix (
    .clk(clk), .a(p_cc), .b(p_lon), .p(p_mix)
  );
  gcd_delay #(.WIDTH(W), .DEPTH(2)) u_lat_d (
    .clk(clk), .rst_n(rst_n), .din(p_lat), .dout(p_lat_d)
  );

  // Sum, saturate flag, root operands
  logic signed [W-1:0] h_sum, h_cl, h_inv;
  logic [VW-1:0]       vx_r, vy_r;
  logic                sat_r, sat_d;

  always_comb begin
    h_sum = p_lat_d + p_mix;
    h_cl  = h_sum[W-1] ? '0 : h_sum;
    h_inv = ONE_F - h_cl;
  end

  always_ff @(posedge clk) begin
    sat_r <= h_sum > ONE_F;
    vx_r  <= VW'(h_inv) << FRAC_BITS;
    vy_r  <= VW'(h_cl) << FRAC_BITS;
  end

  gcd_delay #(.WIDTH(1), .DEPTH(FRAC_BITS + 1 + NS)) u_sat (
    .clk(clk), .rst_n(rst_n), .din(sat_r), .dout(sat_d)
  );

  // Root cell rows for sqrt(1-h) and sqrt(h)
  logic [VW-1:0] qv   [0:1][0:FRAC_BITS+1];
  logic [RW-1:0] qrem [0:1][0:FRAC_BITS+1];
  logic [RW-1:0] qrt  [0:1][0:FRAC_BITS+1];

  assign qv[0][0] = vx_r;
  assign qv[1][0] = vy_r;

  generate
    for (genvar l = 0; l < 2; l++) begin : g_qlane
      assign qrem[l][0] = '0;
      assign qrt[l][0]  = '0;
      for (genvar c = 0; c <= FRAC_BITS; c++) begin : g_qcell
        gcd_root_cell #(.VW(VW), .RW(RW), .BIT(FRAC_BITS - c)) u_cell (
          .clk(clk),
          .v_in(qv[l][c]), .rem_in(qrem[l][c]), .root_in(qrt[l][c]),
          .v_out(qv[l][c+1]), .rem_out(qrem[l][c+1]), .root_out(qrt[l][c+1])
        );
      end
    end
  endgenerate

  // Vectoring cell row for the arc angle
  logic signed [W-1:0] vx [0:NS];
  logic signed [W-1:0] vy [0:NS];
  logic signed [W-1:0] vz [0:NS];

  assign vx[0] = W'(qrt[0][FRAC_BITS+1]);
  assign vy[0] = W'(qrt[1][FRAC_BITS+1]);
  assign vz[0] = '0;

  generate
    for (genvar c = 0; c < NS; c++) begin : g_vcell
      gcd_rot_cell #(.FRAC_BITS(FRAC_BITS), .W(W), .STEP(c), .VECT(1'b1)) u_cell (
        .clk(clk),
        .x_in(vx[c]), .y_in(vy[c]), .z_in(vz[c]),
        .x_out(vx[c+1]), .y_out(vy[c+1]), .z_out(vz[c+1])
      );
    end
  endgenerate

  // Double, clamp and move to Q2.28
  logic signed [63:0] res64, o64;
  logic signed [63:0] sc64;
  logic [29:0]        sep_nxt;

  generate
    if (FRAC_BITS > 28) begin : g_odn
      assign sc64 = (res64 + (64'sd1 <<< (FRAC_BITS - 29))) >>> (FRAC_BITS - 28);
    end else begin : g_oup
      assign sc64 = res64 <<< (28 - FRAC_BITS);
    end
  endgenerate

  always_comb begin
    res64 = 64'(vz[NS]) <<< 1;
    if (sat_d) res64 = 64'(PI_F);
    else if (res64 < 0) res64 = '0;
    else if (res64 > 64'(PI_F)) res64 = 64'(PI_F);
    o64 = sc64;
    if (o64 < 0) sep_nxt = '0;
    else if (o64 > 64'(PI_OUT)) sep_nxt = PI_OUT;
    else sep_nxt = o64[29:0];
  end

  always_ff @(posedge clk) begin
    out_separation <= sep_nxt;
  end

endmodule
